### src/spectral_peak_picker_macros.svh
// Assertion helpers shared by the peak picker modules.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef SPECTRAL_PEAK_PICKER_MACROS_SVH
`define SPECTRAL_PEAK_PICKER_MACROS_SVH

// A condition that holds on every clock edge out of reset.
`define SPP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define SPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define SPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/spp_pkg.sv
package spp_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_BINS    = 4096;
  localparam int FRAC_BITS   = 8;
  localparam int CNT_BITS    = $clog2(MAX_BINS) + 1;
  localparam int IDX_BITS    = $clog2(MAX_BINS);
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int POS_BITS    = 20;
  localparam int AMP_BITS    = 25;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Event queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  // Shared restoring divider. The offset quotient is at most one half bin,
  // the height correction stays below 32 times the largest sample.
  localparam int XQ_STEPS      = FRAC_BITS + 1;
  localparam int EXTRA_STEPS   = SAMPLE_BITS + FRAC_BITS - 2;
  localparam int DIV_NUM_BITS  = 2 * SAMPLE_BITS + FRAC_BITS + 1;
  localparam int DIV_QUO_BITS  = EXTRA_STEPS;
  localparam int DIV_STEP_BITS = $clog2(EXTRA_STEPS + 1);

  // One event handed from the front end to the back end.
  typedef struct packed {
    logic                   has_peak;
    logic                   is_end;
    logic                   rising;
    logic [SAMPLE_BITS-1:0] abs_diff;
    logic [DIFF_BITS-1:0]   curv;
    logic [IDX_BITS-1:0]    idx;
    logic [SAMPLE_BITS-1:0] centre;
    logic [SAMPLE_BITS-1:0] min_peak;
    logic [SAMPLE_BITS-1:0] min_end;
  } cmd_t;

  // Back end sequencer.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FLUSH,
    BK_SQUARE,
    BK_DIV_X,
    BK_DIV_H,
    BK_LAST
  } back_state_t;

endpackage

### src/spp_if.sv
// Input channel: one magnitude bin per transfer.
interface spp_in_if;
  logic                            valid;
  logic                            ready;
  logic [spp_pkg::SAMPLE_BITS-1:0] magnitude;
  logic                            frame_end;

  modport source (output valid, output magnitude, output frame_end, input ready);
  modport sink   (input valid, input magnitude, input frame_end, output ready);
endinterface

// Result channel: one refined peak or end marker per transfer.
interface spp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         peak_valid;
  logic [spp_pkg::POS_BITS-1:0] position;
  logic [spp_pkg::AMP_BITS-1:0] amplitude;
  logic                         last_peak;

  modport source (output valid, output peak_valid, output position, output amplitude,
                  output last_peak, input ready);
  modport sink   (input valid, input peak_valid, input position, input amplitude,
                  input last_peak, output ready);
endinterface

### src/spp_div.sv
`include "spectral_peak_picker_macros.svh"

module spp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [spp_pkg::DIV_NUM_BITS-1:0]    num,
  input  logic [spp_pkg::DIV_NUM_BITS-1:0]    den_sh,
  input  logic [spp_pkg::DIV_STEP_BITS-1:0]   steps,
  output logic                                busy,
  output logic                                done,
  output logic [spp_pkg::DIV_QUO_BITS-1:0]    quo
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [spp_pkg::DIV_STEP_BITS-1:0]  cnt_r, cnt_nxt;
  logic [spp_pkg::DIV_NUM_BITS-1:0]   rem_r, rem_nxt;
  logic [spp_pkg::DIV_NUM_BITS-1:0]   dsh_r, dsh_nxt;
  logic [spp_pkg::DIV_QUO_BITS-1:0]   q_r, q_nxt;
  logic                               fits;

  // One quotient bit per cycle, most significant first; the divisor
  // arrives pre-aligned to the top quotient bit and walks down.
  assign fits = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps - spp_pkg::DIV_STEP_BITS'(1);
      rem_nxt  = num;
      dsh_nxt  = den_sh;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_r - dsh_r) : rem_r;
      q_nxt   = {q_r[spp_pkg::DIV_QUO_BITS-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - spp_pkg::DIV_STEP_BITS'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

  `SPP_ASSERT_NEXT(a_div_start_busy, start, busy_r, "divider did not start")
  `SPP_ASSERT_NOW(a_div_done_idle, done_r, !busy_r, "divider done while still busy")

endmodule

### src/spp_fifo.sv
`include "spectral_peak_picker_macros.svh"

module spp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output spp_pkg::cmd_t head_cmd
);

  spp_pkg::cmd_t                  ent_r [spp_pkg::QUEUE_DEPTH];
  logic [spp_pkg::QPTR_BITS-1:0]  wr_r, wr_nxt;
  logic [spp_pkg::QPTR_BITS-1:0]  rd_r, rd_nxt;
  logic [spp_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == spp_pkg::QCNT_BITS'(spp_pkg::QUEUE_DEPTH));
  assign avail    = (cnt_r != '0);
  assign head_cmd = ent_r[rd_r];

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_nxt  = push ? wr_r + spp_pkg::QPTR_BITS'(1) : wr_r;
    rd_nxt  = pop ? rd_r + spp_pkg::QPTR_BITS'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + spp_pkg::QCNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - spp_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_cmd;
    end
  end

  `SPP_ASSERT_ALWAYS(a_fifo_bound, cnt_r <= spp_pkg::QCNT_BITS'(spp_pkg::QUEUE_DEPTH), "queue over depth")
  `SPP_ASSERT_NOW(a_fifo_no_overrun, push, !full || pop, "push into a full queue")
  `SPP_ASSERT_NOW(a_fifo_no_underrun, pop, avail, "pop from an empty queue")

endmodule

### src/spp_front.sv
module spp_front (
  input  logic           clk,
  input  logic           rst_n,
  spp_in_if.sink         in_chan,
  input  logic           q_full,
  output logic           push,
  output spp_pkg::cmd_t  push_cmd
);

  logic [spp_pkg::SAMPLE_BITS-1:0] older_r, older_nxt;
  logic [spp_pkg::SAMPLE_BITS-1:0] newer_r, newer_nxt;
  logic [spp_pkg::CNT_BITS-1:0]    bins_r, bins_nxt;
  logic [spp_pkg::SAMPLE_BITS-1:0] run_min_r, run_min_nxt;
  logic                            seen_r, seen_nxt;

  logic                            accept;
  logic [spp_pkg::SAMPLE_BITS-1:0] cur;
  logic                            is_peak;
  logic [spp_pkg::SAMPLE_BITS-1:0] min_mid;
  logic                            seen_mid;
  logic [spp_pkg::SAMPLE_BITS-1:0] min_end;
  logic [spp_pkg::DIFF_BITS:0]     curv_full;
  logic [spp_pkg::CNT_BITS-1:0]    idx_full;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign cur           = in_chan.magnitude;

  // The middle bin of the window is a peak when it beats both neighbors.
  assign is_peak = (bins_r >= spp_pkg::CNT_BITS'(2)) && (newer_r > older_r) && (newer_r > cur);

  // Minimum tracking: a non-peak middle bin joins the minimum, a peak restarts it.
  always_comb begin
    min_mid  = run_min_r;
    seen_mid = seen_r;
    if (is_peak) begin
      min_mid  = '0;
      seen_mid = 1'b0;
    end else if (bins_r != '0) begin
      min_mid  = (!seen_r || newer_r < run_min_r) ? newer_r : run_min_r;
      seen_mid = 1'b1;
    end
    min_end = (!seen_mid || cur < min_mid) ? cur : min_mid;
  end

  // Curvature and slope terms for the parabola fit.
  assign curv_full = {1'b0, newer_r, 1'b0} - {2'b00, older_r} - {2'b00, cur};
  assign idx_full  = bins_r - spp_pkg::CNT_BITS'(1);

  always_comb begin
    push_cmd.has_peak = is_peak;
    push_cmd.is_end   = in_chan.frame_end;
    push_cmd.rising   = (cur >= older_r);
    push_cmd.abs_diff = (cur >= older_r) ? (cur - older_r) : (older_r - cur);
    push_cmd.curv     = curv_full[spp_pkg::DIFF_BITS-1:0];
    push_cmd.idx      = idx_full[spp_pkg::IDX_BITS-1:0];
    push_cmd.centre   = newer_r;
    push_cmd.min_peak = run_min_r;
    push_cmd.min_end  = min_end;
  end

  assign push = accept && (is_peak || in_chan.frame_end);

  // Window and frame state; the frame end puts everything back to reset.
  always_comb begin
    older_nxt   = older_r;
    newer_nxt   = newer_r;
    bins_nxt    = bins_r;
    run_min_nxt = run_min_r;
    seen_nxt    = seen_r;
    if (accept) begin
      if (in_chan.frame_end) begin
        older_nxt   = '0;
        newer_nxt   = '0;
        bins_nxt    = '0;
        run_min_nxt = '0;
        seen_nxt    = 1'b0;
      end else begin
        older_nxt   = newer_r;
        newer_nxt   = cur;
        run_min_nxt = min_mid;
        seen_nxt    = seen_mid;
        if (bins_r < spp_pkg::CNT_BITS'(spp_pkg::MAX_BINS)) begin
          bins_nxt = bins_r + spp_pkg::CNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r   <= '0;
      newer_r   <= '0;
      bins_r    <= '0;
      run_min_r <= '0;
      seen_r    <= 1'b0;
    end else begin
      older_r   <= older_nxt;
      newer_r   <= newer_nxt;
      bins_r    <= bins_nxt;
      run_min_r <= run_min_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

### src/spp_back.sv
`include "spectral_peak_picker_macros.svh"

module spp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_avail,
  input  spp_pkg::cmd_t q_cmd,
  output logic          q_pop,
  spp_out_if.source     out_chan
);

  spp_pkg::back_state_t               state_r, state_nxt;
  spp_pkg::cmd_t                      cmd_r;
  logic [2*spp_pkg::SAMPLE_BITS-1:0]  sq_r;
  logic [spp_pkg::XQ_STEPS-1:0]       xq_r;

  logic                               pend_valid_r, pend_valid_nxt;
  logic [spp_pkg::POS_BITS-1:0]       pend_pos_r;
  logic [spp_pkg::AMP_BITS-1:0]       pend_amp_r;
  logic [spp_pkg::SAMPLE_BITS-1:0]    mb_pend_r;

  logic                               out_valid_r;
  logic                               out_peak_r;
  logic [spp_pkg::POS_BITS-1:0]       out_pos_r;
  logic [spp_pkg::AMP_BITS-1:0]       out_amp_r;
  logic                               out_last_r;

  logic                               out_free;
  logic                               emit, emit_last;
  logic                               ld_xq, ld_peak;
  logic                               div_start, div_busy, div_done;
  logic                               sel_extra;
  logic [spp_pkg::DIV_NUM_BITS-1:0]   div_num, div_den;
  logic [spp_pkg::DIV_STEP_BITS-1:0]  div_steps;
  logic [spp_pkg::DIV_QUO_BITS-1:0]   div_quo;

  logic [spp_pkg::SAMPLE_BITS-1:0]    min_sel;
  logic [spp_pkg::SAMPLE_BITS:0]      min_sum;
  logic [spp_pkg::AMP_BITS-1:0]       amp_sub;
  logic [spp_pkg::AMP_BITS-1:0]       amp_red;
  logic [spp_pkg::POS_BITS-1:0]       base;
  logic [spp_pkg::POS_BITS:0]         pos_up;
  logic [spp_pkg::POS_BITS-1:0]       xq_ext;
  logic [spp_pkg::POS_BITS-1:0]       pos_new;
  logic [spp_pkg::AMP_BITS-1:0]       amp_new;

  assign out_free = !out_valid_r || out_chan.ready;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spp_pkg::BK_IDLE: begin
        if (q_avail) state_nxt = spp_pkg::BK_FLUSH;
      end
      spp_pkg::BK_FLUSH: begin
        if (!cmd_r.has_peak) begin
          state_nxt = spp_pkg::BK_LAST;
        end else if (!pend_valid_r || out_free) begin
          state_nxt = spp_pkg::BK_SQUARE;
        end
      end
      spp_pkg::BK_SQUARE: state_nxt = spp_pkg::BK_DIV_X;
      spp_pkg::BK_DIV_X: begin
        if (div_done) state_nxt = spp_pkg::BK_DIV_H;
      end
      spp_pkg::BK_DIV_H: begin
        if (div_done) state_nxt = cmd_r.is_end ? spp_pkg::BK_LAST : spp_pkg::BK_IDLE;
      end
      spp_pkg::BK_LAST: begin
        if (out_free) state_nxt = spp_pkg::BK_IDLE;
      end
      default: state_nxt = spp_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    ld_xq     = 1'b0;
    ld_peak   = 1'b0;
    div_start = 1'b0;
    sel_extra = 1'b0;
    min_sel   = cmd_r.min_peak;
    unique case (state_r)
      spp_pkg::BK_IDLE:   q_pop = q_avail;
      spp_pkg::BK_FLUSH:  emit = cmd_r.has_peak && pend_valid_r && out_free;
      spp_pkg::BK_SQUARE: div_start = 1'b1;
      spp_pkg::BK_DIV_X: begin
        sel_extra = 1'b1;
        if (div_done) begin
          ld_xq     = 1'b1;
          div_start = 1'b1;
        end
      end
      spp_pkg::BK_DIV_H:  ld_peak = div_done;
      spp_pkg::BK_LAST: begin
        emit      = out_free;
        emit_last = 1'b1;
        min_sel   = cmd_r.min_end;
      end
      default: q_pop = 1'b0;
    endcase
  end

  // Divider operands: offset is |N|/(2D), height correction is N^2/(8D),
  // both with round half up and the divisor aligned to the top quotient bit.
  always_comb begin
    if (sel_extra) begin
      div_num   = spp_pkg::DIV_NUM_BITS'({sq_r, {spp_pkg::FRAC_BITS{1'b0}}})
                + spp_pkg::DIV_NUM_BITS'({cmd_r.curv, 2'b00});
      div_den   = spp_pkg::DIV_NUM_BITS'(cmd_r.curv) << (spp_pkg::EXTRA_STEPS + 2);
      div_steps = spp_pkg::DIV_STEP_BITS'(spp_pkg::EXTRA_STEPS);
    end else begin
      div_num   = spp_pkg::DIV_NUM_BITS'({cmd_r.abs_diff, {spp_pkg::FRAC_BITS{1'b0}}})
                + spp_pkg::DIV_NUM_BITS'(cmd_r.curv);
      div_den   = spp_pkg::DIV_NUM_BITS'(cmd_r.curv) << spp_pkg::XQ_STEPS;
      div_steps = spp_pkg::DIV_STEP_BITS'(spp_pkg::XQ_STEPS);
    end
  end

  spp_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den_sh (div_den),
    .steps  (div_steps),
    .busy   (div_busy),
    .done   (div_done),
    .quo    (div_quo)
  );

  // Refined position and height of the new peak.
  assign base    = {cmd_r.idx, {spp_pkg::FRAC_BITS{1'b0}}};
  assign xq_ext  = spp_pkg::POS_BITS'(xq_r);
  assign pos_up  = {1'b0, base} + {1'b0, xq_ext};
  always_comb begin
    if (cmd_r.rising) begin
      pos_new = (pos_up > {1'b0, spp_pkg::POS_MAX}) ? spp_pkg::POS_MAX
                                                    : pos_up[spp_pkg::POS_BITS-1:0];
    end else begin
      pos_new = (xq_ext > base) ? '0 : (base - xq_ext);
    end
  end
  assign amp_new = spp_pkg::AMP_BITS'({cmd_r.centre, {spp_pkg::FRAC_BITS{1'b0}}})
                 + spp_pkg::AMP_BITS'(div_quo);

  // Held height less the mean of the minima on both sides, floored at zero.
  assign min_sum = {1'b0, mb_pend_r} + {1'b0, min_sel};
  assign amp_sub = spp_pkg::AMP_BITS'({min_sum, {(spp_pkg::FRAC_BITS-1){1'b0}}});
  assign amp_red = (pend_amp_r > amp_sub) ? (pend_amp_r - amp_sub) : '0;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (ld_peak) begin
      pend_valid_nxt = 1'b1;
    end else if (emit && emit_last) begin
      pend_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spp_pkg::BK_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    sq_r <= cmd_r.abs_diff * cmd_r.abs_diff;
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (ld_xq) begin
      xq_r <= div_quo[spp_pkg::XQ_STEPS-1:0];
    end
    if (ld_peak) begin
      pend_pos_r <= pos_new;
      pend_amp_r <= amp_new;
      mb_pend_r  <= cmd_r.min_peak;
    end
    if (emit) begin
      out_peak_r <= pend_valid_r;
      out_pos_r  <= pend_valid_r ? pend_pos_r : '0;
      out_amp_r  <= pend_valid_r ? amp_red : '0;
      out_last_r <= emit_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.peak_valid = out_peak_r;
  assign out_chan.position   = out_pos_r;
  assign out_chan.amplitude  = out_amp_r;
  assign out_chan.last_peak  = out_last_r;

  `SPP_ASSERT_NOW(a_back_idle_div, state_r == spp_pkg::BK_IDLE, !div_busy, "divider busy while idle")
  `SPP_ASSERT_NEXT(a_back_end_clears, emit && emit_last, !pend_valid_r, "peak held past frame end")

endmodule

### src/spectral_peak_picker.sv
// Streaming spectral peak picker with three-point parabolic refinement.
// in_chan carries one unsigned magnitude bin per transfer, in ascending
// frequency order, with frame_end on the last bin of a frame. out_chan
// carries refined peaks: position and amplitude in 1/256 units. A peak is
// sent once the next peak is found or the frame ends; the frame end always
// yields a final transfer with last_peak set, and peak_valid clear if the
// frame had no peak.
// The front end takes one bin per cycle while the queue is not full and
// queues an event for each peak and frame end (queue of four). The back
// end refines a peak with the shared one-bit-per-cycle divider (9 offset
// bits, then 22 height bits). The bin after a peak thus stalls in_chan
// only when the queue is full. A result reaches out_chan from the output
// register and waits there until taken. While out_chan is stalled the
// back end holds, the queue fills, and then in_chan.ready drops.
// Reset (synchronous, active low) empties the queue and clears all frame
// state; the first accepted bin afterwards starts a new frame.
module spectral_peak_picker (
  input  logic       clk,
  input  logic       rst_n,
  spp_in_if.sink     in_chan,
  spp_out_if.source  out_chan
);

  logic          push, full, pop, avail;
  spp_pkg::cmd_t push_cmd, head_cmd;

  spp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  spp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head_cmd (head_cmd)
  );

  spp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_avail  (avail),
    .q_cmd    (head_cmd),
    .q_pop    (pop),
    .out_chan (out_chan)
  );

endmodule

### test/tb_spectral_peak_picker.sv
module tb_spectral_peak_picker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned DRAIN_CYCLES  = 80;
  localparam int unsigned DIRECTED_BINS = 25;
  localparam int unsigned RANDOM_BINS   = 475;

  typedef struct {
    logic [spp_pkg::SAMPLE_BITS-1:0] magnitude;
    logic                            frame_end;
  } bin_item_t;

  typedef struct {
    logic                         peak_valid;
    logic [spp_pkg::POS_BITS-1:0] position;
    logic [spp_pkg::AMP_BITS-1:0] amplitude;
    logic                         last_peak;
  } peak_result_t;

  logic clk;
  logic rst_n;

  spp_in_if  in_bus ();
  spp_out_if out_bus ();

  spectral_peak_picker i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Stimulus and expected peaks.
  bin_item_t    bins_to_send[$];
  peak_result_t peaks_due[$];
  int unsigned  bins_queued   = 0;
  int unsigned  bins_accepted = 0;
  int unsigned  errors        = 0;

  // Shadow copy of the peak tracking state.
  logic [spp_pkg::SAMPLE_BITS-1:0] older_bin     = '0;
  logic [spp_pkg::SAMPLE_BITS-1:0] newer_bin     = '0;
  int unsigned                     bins_seen     = 0;
  logic [spp_pkg::SAMPLE_BITS-1:0] valley_level  = '0;
  bit                              valley_seen   = 1'b0;
  logic [spp_pkg::SAMPLE_BITS-1:0] valley_before = '0;
  logic [spp_pkg::POS_BITS-1:0]    held_position = '0;
  longint unsigned                 held_height   = 0;
  bit                              held_valid    = 1'b0;

  // Handshake pacing.
  int unsigned send_gap   = 0;
  int unsigned hold_left  = 0;
  int unsigned cycle_no   = 0;
  int unsigned idle_count = 0;
  bit          steady_in  = 1'b0;
  bit          steady_out = 1'b0;
  bin_item_t   next_bin;
  peak_result_t due;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The lowest non-peak bin since the last peak.
  function automatic void note_valley(input logic [spp_pkg::SAMPLE_BITS-1:0] level);
    if (!valley_seen || level < valley_level) begin
      valley_level = level;
    end
    valley_seen = 1'b1;
  endfunction

  // Held peak height less the mean of the valleys on both sides, clamped to the field.
  function automatic logic [spp_pkg::AMP_BITS-1:0] net_height();
    longint unsigned floor_sum;
    longint unsigned diff;
    floor_sum = valley_before;
    floor_sum = (floor_sum + valley_level) << (spp_pkg::FRAC_BITS - 1);
    if (floor_sum >= held_height) begin
      return '0;
    end
    diff = held_height - floor_sum;
    if (diff > {spp_pkg::AMP_BITS{1'b1}}) begin
      return '1;
    end
    return diff[spp_pkg::AMP_BITS-1:0];
  endfunction

  // Append one expected result to the scoreboard.
  function automatic void expect_result(input peak_result_t res);
    peaks_due = {peaks_due, res};
  endfunction

  // Advance the shadow state by one bin and queue the peaks it releases.
  task automatic track_peaks(input logic [spp_pkg::SAMPLE_BITS-1:0] magnitude,
                             input logic frame_end);
    longint unsigned left, centre, right, curv, span, offset, lift, base, pos, height;
    peak_result_t    res;
    right = magnitude;
    if (bins_seen >= 1) begin
      left   = older_bin;
      centre = newer_bin;
      if (bins_seen >= 2 && centre > left && centre > right) begin
        curv   = 2 * centre - left - right;
        span   = (right >= left) ? right - left : left - right;
        offset = ((span << spp_pkg::FRAC_BITS) + curv) / (2 * curv);
        lift   = (((span * span) << spp_pkg::FRAC_BITS) + 4 * curv) / (8 * curv);
        base   = longint'(bins_seen - 1) << spp_pkg::FRAC_BITS;
        if (right >= left) begin
          pos = base + offset;
        end else begin
          pos = (offset > base) ? 0 : base - offset;
        end
        height = (centre << spp_pkg::FRAC_BITS) + lift;
        if (held_valid) begin
          res.peak_valid = 1'b1;
          res.position   = held_position;
          res.amplitude  = net_height();
          res.last_peak  = 1'b0;
          expect_result(res);
        end
        valley_before = valley_level;
        valley_level  = '0;
        valley_seen   = 1'b0;
        held_position = (pos > spp_pkg::POS_MAX) ? spp_pkg::POS_MAX
                                                 : pos[spp_pkg::POS_BITS-1:0];
        held_height   = height;
        held_valid    = 1'b1;
      end else begin
        note_valley(newer_bin);
      end
    end
    older_bin = newer_bin;
    newer_bin = magnitude;
    if (bins_seen < spp_pkg::MAX_BINS) begin
      bins_seen++;
    end
    // The last bin of a frame always closes it with a marked result.
    if (frame_end) begin
      note_valley(magnitude);
      res.peak_valid = held_valid;
      res.position   = held_valid ? held_position : '0;
      res.amplitude  = held_valid ? net_height() : '0;
      res.last_peak  = 1'b1;
      expect_result(res);
      older_bin     = '0;
      newer_bin     = '0;
      bins_seen     = 0;
      valley_level  = '0;
      valley_seen   = 1'b0;
      valley_before = '0;
      held_position = '0;
      held_height   = 0;
      held_valid    = 1'b0;
    end
  endtask

  function automatic void queue_bin(input int unsigned level, input bit frame_end);
    bin_item_t item;
    item.magnitude = level[spp_pkg::SAMPLE_BITS-1:0];
    item.frame_end = frame_end;
    bins_to_send = {bins_to_send, item};
    bins_queued++;
  endfunction

  function automatic void queue_frame(input int unsigned shape[$]);
    foreach (shape[i]) begin
      queue_bin(shape[i], i == shape.size() - 1);
    end
  endfunction

  // A frame of random length in one of several shapes.
  function automatic void queue_random_frame();
    int unsigned len, style, roll, level;
    int          walk;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      len = $urandom_range(2, 24);
    end else if (roll < 90) begin
      len = $urandom_range(25, 64);
    end else begin
      len = $urandom_range(1, 3);
    end
    style = $urandom_range(0, 4);
    walk  = $urandom_range(0, 65535);
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0: begin
          level = $urandom_range(0, 65535);
        end
        1: begin
          level = $urandom_range(0, 7);
        end
        2: begin
          level = (i % 2) ? $urandom_range(30000, 65535) : $urandom_range(0, 30000);
        end
        3: begin
          walk = walk + int'($urandom_range(0, 4000)) - 2000;
          if (walk < 0) walk = 0;
          if (walk > 65535) walk = 65535;
          level = walk;
        end
        default: begin
          roll  = $urandom_range(0, 3);
          level = (roll < 2) ? roll : 65534 + roll - 2;
        end
      endcase
      queue_bin(level, i == len - 1);
    end
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_pause(input bit steady);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  // Stretches without idling on either side.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no[7:0] == 8'd0) begin
      steady_in  <= ($urandom_range(0, 3) == 0);
      steady_out <= ($urandom_range(0, 3) == 0);
    end
  end

  // Input driver: predict on each transfer, then present the next bin.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid     <= 1'b0;
      in_bus.magnitude <= '0;
      in_bus.frame_end <= 1'b0;
      send_gap         <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        track_peaks(in_bus.magnitude, in_bus.frame_end);
        bins_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (bins_to_send.size() != 0) begin
          next_bin         = bins_to_send.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.magnitude <= next_bin.magnitude;
          in_bus.frame_end <= next_bin.frame_end;
          send_gap         <= pick_pause(steady_in);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expected peak.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (peaks_due.size() == 0) begin
          $display("%0t: expected no result, got peak_valid=%0d position=%0d amplitude=%0d last=%0d",
                   $time, out_bus.peak_valid, out_bus.position, out_bus.amplitude,
                   out_bus.last_peak);
          errors++;
        end else begin
          due = peaks_due.pop_front();
          if (out_bus.peak_valid !== due.peak_valid) begin
            $display("%0t: peak_valid expected %0d, got %0d", $time, due.peak_valid,
                     out_bus.peak_valid);
            errors++;
          end
          if (out_bus.position !== due.position) begin
            $display("%0t: position expected %0d, got %0d", $time, due.position,
                     out_bus.position);
            errors++;
          end
          if (out_bus.amplitude !== due.amplitude) begin
            $display("%0t: amplitude expected %0d, got %0d", $time, due.amplitude,
                     out_bus.amplitude);
            errors++;
          end
          if (out_bus.last_peak !== due.last_peak) begin
            $display("%0t: last_peak expected %0d, got %0d", $time, due.last_peak,
                     out_bus.last_peak);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        hold_left     <= pick_pause(steady_out);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_count <= 0;
      end else begin
        idle_count <= idle_count + 1;
      end
      if (idle_count >= IDLE_LIMIT) begin
        $display("tb_spectral_peak_picker: FAIL");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned shape[$];
    rst_n = 1'b0;

    // A lone bin, extremes, rising and falling offsets, a plateau and a short frame.
    shape = '{0};
    queue_frame(shape);
    shape = '{0, 65535, 0};
    queue_frame(shape);
    shape = '{100, 300, 200, 50, 400, 10};
    queue_frame(shape);
    shape = '{5, 9, 9, 5};
    queue_frame(shape);
    shape = '{0, 65535, 65534};
    queue_frame(shape);
    shape = '{65535, 65535, 0, 1, 0, 65535};
    queue_frame(shape);
    shape = '{7, 3};
    queue_frame(shape);

    // Random frames of varied length and shape.
    while (bins_queued < DIRECTED_BINS + RANDOM_BINS) begin
      queue_random_frame();
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (bins_accepted < bins_queued || peaks_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_spectral_peak_picker: PASS");
    end else begin
      $display("tb_spectral_peak_picker: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/spp_pkg.sv
src/spp_if.sv
src/spp_div.sv
src/spp_fifo.sv
src/spp_front.sv
src/spp_back.sv
src/spectral_peak_picker.sv
test/tb_spectral_peak_picker.sv
